FILE: rtl/core/quad_timer_with_usec_counter_core_macros.svh
// assertion macros for the timer bank core
`ifndef QUAD_TIMER_WITH_USEC_COUNTER_CORE_MACROS_SVH
`define QUAD_TIMER_WITH_USEC_COUNTER_CORE_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define QTU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timer core check failed");

// next-cycle implication, clocked on aclk, off during reset
`define QTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timer core check failed");

`endif

FILE: rtl/core/qtu_pkg.sv
// types and constants shared by the timer bank core
package qtu_pkg;

    localparam int unsigned MAX_TIMERS = 4;
    localparam int unsigned CNT_W      = 29;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // register offsets
    localparam logic [11:0] OFF_USEC   = 12'h010;
    localparam logic [11:0] OFF_CFG    = 12'h014;
    localparam logic [11:0] OFF_FREEZE = 12'h04C;
    localparam logic [11:0] OFF_CTR    = 12'h004;

    localparam logic [11:0] TIMER_BASE [MAX_TIMERS] = '{12'h000, 12'h008, 12'h050, 12'h058};

    localparam int unsigned START_BIT = 31;
    localparam int unsigned MODE_BIT  = 30;

    localparam logic [15:0] CFG_RESET = 16'h000C;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] offset;
        logic [31:0] write_data;
    } qtu_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  irq_lines;
        logic        bad_access;
    } qtu_out_t;

    typedef struct packed {
        logic       hit_timer;
        logic       is_ctr;
        logic [1:0] idx;
        logic       hit_usec;
        logic       hit_cfg;
        logic       hit_freeze;
    } qtu_dec_t;

    typedef struct packed {
        logic tick;
        logic wr_preset;
        logic wr_ctr;
    } qtu_timer_ctl_t;

endpackage

FILE: rtl/core/qtu_decode.sv
// register offset decoder for the timer bank
module qtu_decode #(
    parameter int unsigned NUM_TIMERS = 4
) (
    input  logic [11:0]       offset,
    output qtu_pkg::qtu_dec_t dec
);

    always_comb begin
        dec            = '0;
        dec.hit_usec   = (offset == qtu_pkg::OFF_USEC);
        dec.hit_cfg    = (offset == qtu_pkg::OFF_CFG);
        dec.hit_freeze = (offset == qtu_pkg::OFF_FREEZE);
        // timers above the configured count decode as unknown
        for (int i = 0; i < int'(qtu_pkg::MAX_TIMERS); i++) begin
            if (i < int'(NUM_TIMERS)) begin
                if (offset == qtu_pkg::TIMER_BASE[i]) begin
                    dec.hit_timer = 1'b1;
                    dec.is_ctr    = 1'b0;
                    dec.idx       = 2'(i);
                end else if (offset == (qtu_pkg::TIMER_BASE[i] + qtu_pkg::OFF_CTR)) begin
                    dec.hit_timer = 1'b1;
                    dec.is_ctr    = 1'b1;
                    dec.idx       = 2'(i);
                end
            end
        end
    end

endmodule

FILE: rtl/core/qtu_timer.sv
// one 29-bit down-count timer channel
module qtu_timer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qtu_pkg::qtu_timer_ctl_t       ctl,
    input  logic [31:0]                   wdata,
    output logic [qtu_pkg::CNT_W-1:0]     count,
    output logic [31:0]                   preset,
    output logic                          irq_next
);

    logic [31:0]               preset_reg,   preset_next;
    logic [qtu_pkg::CNT_W-1:0] count_reg,    count_next;
    logic                      running_reg,  running_next;
    logic                      periodic_reg, periodic_next;
    logic                      irq_reg;
    logic [qtu_pkg::CNT_W-1:0] dec_cnt;

    // a zero count fires without counting down
    assign dec_cnt = (count_reg != '0) ? (count_reg - 1'b1) : '0;

    always_comb begin
        preset_next   = preset_reg;
        count_next    = count_reg;
        running_next  = running_reg;
        periodic_next = periodic_reg;
        irq_next      = irq_reg;
        if (ctl.tick && running_reg) begin
            count_next = dec_cnt;
            if (dec_cnt == '0) begin
                irq_next = 1'b1;
                if (periodic_reg) begin
                    count_next = preset_reg[qtu_pkg::CNT_W-1:0];
                end else begin
                    running_next = 1'b0;
                end
            end
        end
        if (ctl.wr_preset) begin
            preset_next   = wdata;
            count_next    = wdata[qtu_pkg::CNT_W-1:0];
            running_next  = wdata[qtu_pkg::START_BIT];
            periodic_next = wdata[qtu_pkg::MODE_BIT];
        end
        if (ctl.wr_ctr && wdata[qtu_pkg::MODE_BIT]) begin
            irq_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preset_reg   <= '0;
            count_reg    <= '0;
            running_reg  <= 1'b0;
            periodic_reg <= 1'b0;
            irq_reg      <= 1'b0;
        end else begin
            preset_reg   <= preset_next;
            count_reg    <= count_next;
            running_reg  <= running_next;
            periodic_reg <= periodic_next;
            irq_reg      <= irq_next;
        end
    end

    assign count  = count_reg;
    assign preset = preset_reg;

endmodule

FILE: rtl/core/quad_timer_with_usec_counter_core.sv
// top level of the timer bank core: beat registers, usec counter, read mux
`include "quad_timer_with_usec_counter_core_macros.svh"

// Bank of NUM_TIMERS 29-bit down-count timers plus a free-running 32-bit
// microsecond counter behind a 4 KiB register window. Every input beat (a
// one-microsecond tick, a register read or a register write) produces exactly
// one result beat carrying the read data, the interrupt level of every timer
// after that beat, and an error flag for unknown offsets or writes to the
// read-only microsecond counter. One beat is taken per clock; a beat goes
// into an input register, is processed by the decoder and the timer channels
// once the result register is free or being drained, and then lands in the
// result register, where it is held valid until m_ready takes it. The input
// side stalls only while the result register holds a beat that m_ready has
// not taken.
module quad_timer_with_usec_counter_core #(
    parameter int unsigned NUM_TIMERS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qtu_pkg::qtu_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output qtu_pkg::qtu_out_t m_data
);

    // input stage
    logic             in_vld_reg;
    qtu_pkg::qtu_in_t in_item_reg;

    // result stage
    logic              out_vld_reg;
    qtu_pkg::qtu_out_t out_data_reg, out_data_next;

    // global registers
    logic [31:0] usec_reg, usec_next;
    logic [15:0] cfg_reg,  cfg_next;

    logic             fire;
    logic             is_tick, is_write;
    qtu_pkg::qtu_dec_t dec;

    logic [qtu_pkg::CNT_W-1:0] tmr_count [NUM_TIMERS];
    logic [31:0]               tmr_preset [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]     tmr_irq_next;

    // process when the result register is free or being drained
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    assign is_tick  = fire && (in_item_reg.action == qtu_pkg::ACT_TICK);
    assign is_write = fire && (in_item_reg.action == qtu_pkg::ACT_WRITE);

    qtu_decode #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_decode (
        .offset(in_item_reg.offset),
        .dec   (dec)
    );

    // timer channels, all stepping in parallel on a tick
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        qtu_pkg::qtu_timer_ctl_t ctl;
        logic                    sel;

        assign sel           = dec.hit_timer && (dec.idx == 2'(g));
        assign ctl.tick      = is_tick;
        assign ctl.wr_preset = is_write && sel && !dec.is_ctr;
        assign ctl.wr_ctr    = is_write && sel && dec.is_ctr;

        qtu_timer u_timer (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .wdata   (in_item_reg.write_data),
            .count   (tmr_count[g]),
            .preset  (tmr_preset[g]),
            .irq_next(tmr_irq_next[g])
        );
    end

    // usec counter and config register
    always_comb begin
        usec_next = usec_reg;
        cfg_next  = cfg_reg;
        if (is_tick) begin
            usec_next = usec_reg + 32'd1;
        end
        if (is_write && !dec.hit_timer && dec.hit_cfg) begin
            cfg_next = in_item_reg.write_data[15:0];
        end
    end

    // result word: read mux, error flag, interrupt levels after this beat
    always_comb begin
        out_data_next            = '0;
        out_data_next.irq_lines  = 4'(tmr_irq_next);
        if (in_item_reg.action == qtu_pkg::ACT_READ) begin
            if (dec.hit_timer) begin
                for (int i = 0; i < int'(NUM_TIMERS); i++) begin
                    if (dec.idx == 2'(i)) begin
                        out_data_next.read_data = dec.is_ctr ? 32'(tmr_count[i])
                                                             : tmr_preset[i];
                    end
                end
            end else if (dec.hit_usec) begin
                out_data_next.read_data = usec_reg;
            end else if (dec.hit_cfg) begin
                out_data_next.read_data = 32'(cfg_reg);
            end else if (!dec.hit_freeze) begin
                out_data_next.bad_access = 1'b1;
            end
        end else if (in_item_reg.action == qtu_pkg::ACT_WRITE) begin
            // usec counter is read only, so it falls into the error arm
            if (!dec.hit_timer && !dec.hit_cfg && !dec.hit_freeze) begin
                out_data_next.bad_access = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            usec_reg    <= '0;
            cfg_reg     <= qtu_pkg::CFG_RESET;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            usec_reg <= usec_next;
            cfg_reg  <= cfg_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    // never overwrite a result that is still waiting
    `QTU_ASSERT_IMPL(a_no_overwrite, fire, !out_vld_reg || m_ready)
    // usec counter advances by one on each processed tick
    `QTU_ASSERT_NEXT(a_usec_tick, is_tick, usec_reg == ($past(usec_reg) + 32'd1))
    // usec counter only moves on a processed beat
    `QTU_ASSERT_NEXT(a_usec_hold, !fire, $stable(usec_reg))
    // flagged beats never carry read data
    `QTU_ASSERT_IMPL(a_bad_zero, out_vld_reg && out_data_reg.bad_access,
        out_data_reg.read_data == 32'd0)
    // no interrupt from timers that are not built
    `QTU_ASSERT_IMPL(a_irq_range, out_vld_reg, (out_data_reg.irq_lines >> NUM_TIMERS) == 4'd0)

endmodule

FILE: sim/qtu_checker.sv
// result checker for the timer bank: predicts each result beat and compares it
module qtu_checker #(
    parameter int unsigned NUM_TIMERS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  qtu_pkg::qtu_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  qtu_pkg::qtu_out_t m_data,
    output int unsigned       mismatches,
    output int unsigned       results_due,
    output int unsigned       results_checked,
    output int unsigned       expirations
);
    timeunit 1ns;
    timeprecision 1ps;

    import qtu_pkg::*;

    localparam int unsigned PRINT_CAP = 40;

    // shadow copy of the timer bank state
    logic [31:0]      preset_word [MAX_TIMERS];
    logic [CNT_W-1:0] down_count  [MAX_TIMERS];
    logic             running     [MAX_TIMERS];
    logic             periodic    [MAX_TIMERS];
    logic             irq_pending [MAX_TIMERS];
    logic [31:0]      usec_count;
    logic [15:0]      usec_config;

    qtu_out_t pending_results [$];
    qtu_out_t want;

    initial begin
        mismatches      = 0;
        results_due     = 0;
        results_checked = 0;
        expirations     = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // advance the shadow state by one input beat and return its result
    function automatic qtu_out_t timer_bank_step(input qtu_in_t beat);
        qtu_out_t res;
        logic     hit_timer;
        logic     hit_ctr;
        int       idx;
        res       = '0;
        hit_timer = 1'b0;
        hit_ctr   = 1'b0;
        idx       = 0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            if (beat.offset == TIMER_BASE[t]) begin
                hit_timer = 1'b1;
                idx       = t;
            end else if (beat.offset == TIMER_BASE[t] + OFF_CTR) begin
                hit_timer = 1'b1;
                hit_ctr   = 1'b1;
                idx       = t;
            end
        end
        case (beat.action)
            ACT_TICK: begin
                usec_count = usec_count + 32'd1;
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (running[t]) begin
                        // a running timer already at zero fires without counting
                        if (down_count[t] != '0)
                            down_count[t] = down_count[t] - 1'b1;
                        if (down_count[t] == '0) begin
                            irq_pending[t] = 1'b1;
                            expirations++;
                            if (periodic[t])
                                down_count[t] = preset_word[t][CNT_W-1:0];
                            else
                                running[t] = 1'b0;
                        end
                    end
                end
            end
            ACT_READ: begin
                if (hit_timer)
                    res.read_data = hit_ctr ? 32'(down_count[idx]) : preset_word[idx];
                else if (beat.offset == OFF_USEC)
                    res.read_data = usec_count;
                else if (beat.offset == OFF_CFG)
                    res.read_data = 32'(usec_config);
                else if (beat.offset != OFF_FREEZE)
                    res.bad_access = 1'b1;
            end
            ACT_WRITE: begin
                if (hit_timer && hit_ctr) begin
                    if (beat.write_data[MODE_BIT])
                        irq_pending[idx] = 1'b0;
                end else if (hit_timer) begin
                    // interrupt level is left alone by a preset write
                    preset_word[idx] = beat.write_data;
                    down_count[idx]  = beat.write_data[CNT_W-1:0];
                    running[idx]     = beat.write_data[START_BIT];
                    periodic[idx]    = beat.write_data[MODE_BIT];
                end else if (beat.offset == OFF_CFG) begin
                    usec_config = beat.write_data[15:0];
                end else if (beat.offset != OFF_FREEZE) begin
                    // unknown offset, or the read-only usec counter
                    res.bad_access = 1'b1;
                end
            end
            default: ;
        endcase
        for (int t = 0; t < NUM_TIMERS; t++)
            res.irq_lines[t] = irq_pending[t];
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < MAX_TIMERS; t++) begin
                preset_word[t] = '0;
                down_count[t]  = '0;
                running[t]     = 1'b0;
                periodic[t]    = 1'b0;
                irq_pending[t] = 1'b0;
            end
            usec_count  = '0;
            usec_config = CFG_RESET;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 32'h0, m_data.read_data);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (m_data.read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, m_data.read_data);
                    if (m_data.irq_lines !== want.irq_lines)
                        report_mismatch("irq_lines", 32'(want.irq_lines), 32'(m_data.irq_lines));
                    if (m_data.bad_access !== want.bad_access)
                        report_mismatch("bad_access", 32'(want.bad_access),
                                        32'(m_data.bad_access));
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(timer_bank_step(s_data));
        end
        results_due <= pending_results.size();
    end

endmodule

FILE: sim/tb_top.sv
// testbench top for the timer bank core: stimulus, back-pressure and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qtu_pkg::*;

    localparam int unsigned NUM_TIMERS   = 4;
    localparam int unsigned RANDOM_BEATS = 1500;
    // last stretch of the run goes without any idling
    localparam int unsigned STEADY_FROM  = 1300;
    // longest legal silence is a sender gap plus a receiver stall plus latency
    localparam int unsigned STALL_LIMIT  = 2000;

    localparam logic [1:0]  ACT_NONE = 2'd3;
    localparam logic [31:0] RUN      = 32'h1 << START_BIT;
    localparam logic [31:0] REPEAT   = 32'h1 << MODE_BIT;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    qtu_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    qtu_out_t m_data;

    int unsigned mismatches;
    int unsigned results_due;
    int unsigned results_checked;
    int unsigned expirations;

    int unsigned ready_hold  = 0;
    int unsigned dead_cycles = 0;
    bit          steady      = 1'b0;

    // tallies for the closing summary
    int unsigned n_ticks  = 0;
    int unsigned n_reads  = 0;
    int unsigned n_writes = 0;
    int unsigned n_noops  = 0;

    always #5 aclk = ~aclk;

    quad_timer_with_usec_counter_core #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    qtu_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatches      (mismatches),
        .results_due     (results_due),
        .results_checked (results_checked),
        .expirations     (expirations)
    );

    // receiver back-pressure: random stall bursts outside the steady stretch
    always @(negedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(1, 12) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: count cycles in which neither channel moves a beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
    end

    initial begin
        wait (dead_cycles >= STALL_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic qtu_in_t mk(input logic [1:0] action, input logic [11:0] offset,
                                   input logic [31:0] data);
        qtu_in_t beat;
        beat.action     = action;
        beat.offset     = offset;
        beat.write_data = data;
        return beat;
    endfunction

    // present one beat, optionally after a sender gap, and hold it until taken
    task automatic send_beat(input qtu_in_t beat);
        if (!steady && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        case (beat.action)
            ACT_TICK:  n_ticks++;
            ACT_READ:  n_reads++;
            ACT_WRITE: n_writes++;
            default:   n_noops++;
        endcase
        @(negedge aclk);
    endtask

    initial begin
        qtu_in_t     directed [$];
        qtu_in_t     beat;
        int unsigned roll;
        int unsigned pick;
        int unsigned t;
        logic [31:0] data;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // usec config reads its reset value
        directed.push_back(mk(ACT_READ, OFF_CFG, '0));
        // one-shot of three, periodic reload of zero, one-shot started at zero
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[0], RUN | 32'd3));
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[1], RUN | REPEAT));
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[2], RUN));
        // all ones: largest count, periodic, upper bits kept in the preset word
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[3], '1));
        directed.push_back(mk(ACT_TICK, '0, '0));
        directed.push_back(mk(ACT_READ, TIMER_BASE[0] + OFF_CTR, '0));
        directed.push_back(mk(ACT_TICK, '1, '1));
        directed.push_back(mk(ACT_TICK, '0, '0));
        directed.push_back(mk(ACT_READ, TIMER_BASE[3] + OFF_CTR, '0));
        // counter write clears the interrupt only with the mode bit set
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[1] + OFF_CTR, REPEAT));
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[0] + OFF_CTR, ~REPEAT));
        // usec counter is read only
        directed.push_back(mk(ACT_WRITE, OFF_USEC, '1));
        directed.push_back(mk(ACT_READ, OFF_USEC, '0));
        directed.push_back(mk(ACT_WRITE, OFF_CFG, '1));
        directed.push_back(mk(ACT_READ, OFF_CFG, '0));
        directed.push_back(mk(ACT_WRITE, OFF_FREEZE, '1));
        directed.push_back(mk(ACT_READ, OFF_FREEZE, '0));
        // unaligned and unknown offsets, and the unused action code
        directed.push_back(mk(ACT_READ, 12'h002, '0));
        directed.push_back(mk(ACT_WRITE, 12'hFFF, '1));
        directed.push_back(mk(ACT_NONE, 12'hFFF, '1));
        // clearing the start bit stops a timer, pending interrupt stays
        directed.push_back(mk(ACT_WRITE, TIMER_BASE[2], REPEAT | 32'd5));
        directed.push_back(mk(ACT_TICK, '0, '0));
        directed.push_back(mk(ACT_READ, TIMER_BASE[3], '0));
        foreach (directed[i])
            send_beat(directed[i]);

        for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
            steady = (i >= STEADY_FROM);
            roll   = $urandom_range(0, 99);
            t      = $urandom_range(0, MAX_TIMERS - 1);
            data   = $urandom;
            if (roll < 45) begin
                // ticks carry junk offset and data, which must be ignored
                beat = mk(ACT_TICK, 12'($urandom), data);
            end else if (roll < 60) begin
                pick = $urandom_range(0, 10);
                if (pick < 8)
                    beat = mk(ACT_READ, TIMER_BASE[pick / 2] + ((pick % 2 != 0) ? OFF_CTR : '0),
                              data);
                else if (pick == 8)
                    beat = mk(ACT_READ, OFF_USEC, data);
                else if (pick == 9)
                    beat = mk(ACT_READ, OFF_CFG, data);
                else
                    beat = mk(ACT_READ, OFF_FREEZE, data);
            end else if (roll < 75) begin
                // mostly short counts so timers expire often, a few huge ones
                if ($urandom_range(0, 9) != 0)
                    data[CNT_W-1:0] = CNT_W'($urandom_range(0, 10));
                data[START_BIT] = ($urandom_range(0, 4) != 0);
                beat = mk(ACT_WRITE, TIMER_BASE[t], data);
            end else if (roll < 83) begin
                beat = mk(ACT_WRITE, TIMER_BASE[t] + OFF_CTR, data);
            end else if (roll < 87) begin
                pick = $urandom_range(0, 2);
                beat = mk(ACT_WRITE, (pick == 0) ? OFF_CFG : (pick == 1) ? OFF_FREEZE : OFF_USEC,
                          data);
            end else if (roll < 95) begin
                beat = mk(($urandom_range(0, 1) != 0) ? ACT_WRITE : ACT_READ, 12'($urandom), data);
            end else begin
                beat = mk(ACT_NONE, 12'($urandom), data);
            end
            send_beat(beat);
        end
        s_valid <= 1'b0;

        // drain, then give any stray result time to show up
        while (results_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d beats: %0d ticks, %0d reads, %0d writes, %0d no-ops",
                 n_ticks + n_reads + n_writes + n_noops, n_ticks, n_reads, n_writes, n_noops);
        $display("checked %0d results, %0d timer expirations along the way",
                 results_checked, expirations);
        if (mismatches == 0 && results_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
